// ----- hdl/swss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swss_pkg
// Shared widths, limits and sequencer states for the sliding window sample
// statistics unit.
// ----------------------------------------------------------------------------
package swss_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int SUM_W       = 56;
    localparam int COUNT_W     = 32;
    localparam int QUOT_W      = 24;
    localparam int DIV_STEP_W  = 5;

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DIVW_START,
        ST_DIVW_WAIT,
        ST_DIVL_START,
        ST_DIVL_WAIT,
        ST_LOAD
    } state_t;

endpackage

// ----- hdl/swss_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swss_ring
// Sample ring memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module swss_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [swss_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [swss_pkg::SAMPLE_W-1:0] rd_data
);
    import swss_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/swss_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swss_div
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// QUOT_W bits, which holds for every mean this block computes.
// ----------------------------------------------------------------------------
module swss_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [swss_pkg::SUM_W-1:0]   dividend,
    input  logic [swss_pkg::COUNT_W-1:0] divisor,
    output logic                         busy,
    output logic                         done,
    output logic [swss_pkg::QUOT_W-1:0]  quotient
);
    import swss_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]      rem_reg;
    logic [SUM_W-1:0]      dsh_reg;
    logic [QUOT_W-1:0]     quot_reg;
    logic                  fits;

    assign fits = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= DIV_STEP_W'(QUOT_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            dsh_reg  <= SUM_W'(divisor) << (QUOT_W - 1);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ----- hdl/sliding_window_sample_stats_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_sample_stats_unit
// Window and lifetime min, max and mean over a stream of 24-bit samples.
// ----------------------------------------------------------------------------
// Each accepted sample is written into a ring of the last WINDOW_DEPTH samples
// and yields one result beat. Each item is handled in these steps, in order:
// the accept, a walk of the ring one entry per cycle through its single
// registered read port, the window mean and then the lifetime mean in one
// shared restoring divider (a start, 24 quotient bits and a done strobe
// each), and a load of the output register, which waits while that register
// still holds a result that the result side has not taken.
// s_tready is high only between items; a finished result waits in the output
// register while the next sample is accepted.
module sliding_window_sample_stats_unit #(
    parameter int WINDOW_DEPTH = 64,
    localparam int FILL_W      = $clog2(WINDOW_DEPTH + 1),
    localparam int OUT_W       = ((6 * 24 + FILL_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // sample_value
    input  logic [23:0]      s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // window_min, window_max, window_mean, lifetime_min, lifetime_max,
    // lifetime_mean, window_fill, zero pad
    output logic [OUT_W-1:0] m_tdata
);
    import swss_pkg::*;

    localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int WSUM_W = SAMPLE_W + FILL_W;

    state_t state_reg;
    state_t state_next;

    logic [AW-1:0]       wp_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [SAMPLE_W-1:0] lmin_reg;
    logic [SAMPLE_W-1:0] lmax_reg;
    logic [SUM_W-1:0]    lsum_reg;
    logic [COUNT_W-1:0]  lcnt_reg;
    logic [SUM_W:0]      lsum_inc;

    logic [FILL_W-1:0]   walk_cnt_reg;
    logic                rd_valid_reg;
    logic [WSUM_W-1:0]   wsum_reg;
    logic [SAMPLE_W-1:0] wmin_reg;
    logic [SAMPLE_W-1:0] wmax_reg;
    logic [QUOT_W-1:0]   wmean_reg;
    logic [QUOT_W-1:0]   lmean_reg;

    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;

    logic                accept;
    logic                rd_en;
    logic [SAMPLE_W-1:0] rd_data;
    logic                div_start;
    logic                div_busy;
    logic                div_done;
    logic [SUM_W-1:0]    div_dividend;
    logic [COUNT_W-1:0]  div_divisor;
    logic [QUOT_W-1:0]   div_quot;
    logic                out_load;
    logic                walk_end;

    swss_ring #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wp_reg),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (walk_cnt_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    swss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign accept   = s_tvalid && s_tready;
    assign walk_end = (walk_cnt_reg == fill_reg) && !rd_valid_reg;
    assign lsum_inc = {1'b0, lsum_reg} + (SUM_W + 1)'(s_tdata);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (s_tvalid) state_next = ST_WALK;
            ST_WALK:       if (walk_end) state_next = ST_DIVW_START;
            ST_DIVW_START: state_next = ST_DIVW_WAIT;
            ST_DIVW_WAIT:  if (div_done) state_next = ST_DIVL_START;
            ST_DIVL_START: state_next = ST_DIVL_WAIT;
            ST_DIVL_WAIT:  if (div_done) state_next = ST_LOAD;
            ST_LOAD:       if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready     = (state_reg == ST_IDLE);
        rd_en        = (state_reg == ST_WALK) && (walk_cnt_reg < fill_reg);
        div_start    = (state_reg == ST_DIVW_START) || (state_reg == ST_DIVL_START);
        out_load     = (state_reg == ST_LOAD) && (!m_tvalid_reg || m_tready);
        if (state_reg == ST_DIVL_START)
        begin
            div_dividend = lsum_reg;
            div_divisor  = lcnt_reg;
        end
        else
        begin
            div_dividend = SUM_W'(wsum_reg);
            div_divisor  = COUNT_W'(fill_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            fill_reg     <= '0;
            lmin_reg     <= '1;
            lmax_reg     <= '0;
            lsum_reg     <= '0;
            lcnt_reg     <= '0;
            walk_cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (s_tdata < lmin_reg) lmin_reg <= s_tdata;
                if (s_tdata > lmax_reg) lmax_reg <= s_tdata;
                if (lcnt_reg != COUNT_MAX)
                begin
                    lcnt_reg <= lcnt_reg + 1'b1;
                    lsum_reg <= (lsum_inc > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX
                                                                  : lsum_inc[SUM_W-1:0];
                end
                wp_reg <= (wp_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                if (fill_reg != FILL_W'(WINDOW_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                walk_cnt_reg <= '0;
                rd_valid_reg <= 1'b0;
            end
            else if (state_reg == ST_WALK)
            begin
                rd_valid_reg <= rd_en;
                if (rd_en)
                begin
                    walk_cnt_reg <= walk_cnt_reg + 1'b1;
                end
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wsum_reg <= '0;
            wmin_reg <= '1;
            wmax_reg <= '0;
        end
        else if ((state_reg == ST_WALK) && rd_valid_reg)
        begin
            wsum_reg <= wsum_reg + WSUM_W'(rd_data);
            if (rd_data < wmin_reg) wmin_reg <= rd_data;
            if (rd_data > wmax_reg) wmax_reg <= rd_data;
        end
        if ((state_reg == ST_DIVW_WAIT) && div_done)
        begin
            wmean_reg <= div_quot;
        end
        if ((state_reg == ST_DIVL_WAIT) && div_done)
        begin
            lmean_reg <= div_quot;
        end
        if (out_load)
        begin
            m_tdata_reg <= OUT_W'({fill_reg, lmean_reg, lmax_reg, lmin_reg,
                                   wmean_reg, wmax_reg, wmin_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_WALK))
        else $error("accepted sample did not start the ring walk");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_load_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_LOAD) && m_tvalid_reg && !m_tready) |=> (state_reg == ST_LOAD))
        else $error("result dropped while output register full");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= FILL_W'(WINDOW_DEPTH)) && (walk_cnt_reg <= fill_reg))
        else $error("fill or walk count out of range");

    a_mean_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> ((m_tdata_reg[23:0] <= m_tdata_reg[71:48])
                       && (m_tdata_reg[71:48] <= m_tdata_reg[47:24])))
        else $error("window mean outside window min and max");

endmodule
